// ----- hdl/bss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bench supply supervisor package
// Shared widths, commands, state codes and register indexes.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int AVG_DEPTH  = 8;
  localparam int SLOT_BITS  = $clog2(AVG_DEPTH);
  localparam int SMP_BITS   = 12;
  localparam int DAC_W      = 12;
  localparam int SUM_BITS   = SMP_BITS + SLOT_BITS;
  localparam int TICK_BITS  = 16;
  localparam int NUM_CH     = 5;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_ENABLE  = 2'd1;
  localparam logic [1:0] FUNC_DISABLE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  localparam logic [2:0] ST_OFF  = 3'd0;
  localparam logic [2:0] ST_SOFT = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_CV   = 3'd3;
  localparam logic [2:0] ST_CC   = 3'd4;
  localparam logic [2:0] ST_OTP  = 3'd5;
  localparam logic [2:0] ST_OVP  = 3'd6;
  localparam logic [2:0] ST_OCP  = 3'd7;

  localparam logic [2:0] REG_VTARGET = 3'd0;
  localparam logic [2:0] REG_ILIMIT  = 3'd1;
  localparam logic [2:0] REG_OV      = 3'd2;
  localparam logic [2:0] REG_OC      = 3'd3;
  localparam logic [2:0] REG_OT      = 3'd4;
  localparam logic [2:0] REG_RECOVER = 3'd5;
  localparam logic [2:0] REG_RAMP    = 3'd6;
  localparam logic [2:0] REG_CCDET   = 3'd7;

  // Division request and answer between the sequencer and the divider.
  typedef struct packed {
    logic                             start;
    logic [DAC_W+TICK_BITS-1:0]       dividend;
    logic [TICK_BITS-1:0]             divisor;
  } div_req_t;

  typedef struct packed {
    logic                             done;
    logic [DAC_W+TICK_BITS-1:0]       quotient;
  } div_rsp_t;

endpackage : bss_pkg
`default_nettype wire

// ----- hdl/bss_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bench supply supervisor divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bss_div
  import bss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int NUM_W = DAC_W + TICK_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [TICK_BITS:0]   rem_r, rem_nxt;
  logic [TICK_BITS-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [TICK_BITS:0]   shifted;

  // One shift and trial subtract per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[TICK_BITS-1:0], quo_r[NUM_W-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule : bss_div
`default_nettype wire

// ----- hdl/bench_supply_supervisor_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Bench supply supervisor top level
// Command sequencer, averaging rings, ramp, protection and CC/CV detection.
// ----------------------------------------------------------------------------
// Each item carries one command. Enable, disable and clear pass through the
// command and output states before their result is presented. A tick that
// advances the soft-start ramp without ending it waits in the divide state
// for the 28-bit restoring divider, which works out the ramp code one quotient
// bit per cycle. Other ticks go straight to the protection checks, with the
// averaging rings updated in the cycle after acceptance. in_stall is high
// from acceptance until the result has been taken, and the result is held in
// the output registers until out_stall is low.
module bench_supply_supervisor_top
  import bss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [11:0] in_vfb_sample,
  input  wire logic [11:0] in_ifb_sample,
  input  wire logic [11:0] in_vin_sample,
  input  wire logic [11:0] in_ntc_sample,
  input  wire logic [11:0] in_cc_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_voltage_dac,
  output logic [11:0]      out_current_dac,
  output logic [2:0]       out_supply_state,
  output logic             out_state_changed,
  output logic             out_output_on,
  output logic [11:0]      out_vfb_average,
  output logic [11:0]      out_ifb_average,
  output logic [11:0]      out_vin_average,
  output logic [11:0]      out_ntc_average,
  output logic [23:0]      out_power_product,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_RING  = 3'd1;
  localparam logic [2:0] SQ_DIV   = 3'd2;
  localparam logic [2:0] SQ_PROT  = 3'd3;
  localparam logic [2:0] SQ_CMD   = 3'd4;
  localparam logic [2:0] SQ_OUT   = 3'd5;
  localparam logic [2:0] SQ_WAIT  = 3'd6;

  // Configuration registers.
  logic [11:0] vtarget_r, ilimit_r, ov_r, oc_r, ot_r, recover_r, ccdet_r;
  logic [15:0] ramp_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtarget_r <= 12'd0;
      ilimit_r  <= 12'd0;
      ov_r      <= 12'd4095;
      oc_r      <= 12'd4095;
      ot_r      <= 12'd0;
      recover_r <= 12'd4095;
      ramp_r    <= 16'd50;
      ccdet_r   <= 12'd1241;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VTARGET: vtarget_r <= cfg_pwdata[11:0];
        REG_ILIMIT:  ilimit_r  <= cfg_pwdata[11:0];
        REG_OV:      ov_r      <= cfg_pwdata[11:0];
        REG_OC:      oc_r      <= cfg_pwdata[11:0];
        REG_OT:      ot_r      <= cfg_pwdata[11:0];
        REG_RECOVER: recover_r <= cfg_pwdata[11:0];
        REG_RAMP:    ramp_r    <= cfg_pwdata[15:0];
        default:     ccdet_r   <= cfg_pwdata[11:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_VTARGET: cfg_prdata = {20'd0, vtarget_r};
      REG_ILIMIT:  cfg_prdata = {20'd0, ilimit_r};
      REG_OV:      cfg_prdata = {20'd0, ov_r};
      REG_OC:      cfg_prdata = {20'd0, oc_r};
      REG_OT:      cfg_prdata = {20'd0, ot_r};
      REG_RECOVER: cfg_prdata = {20'd0, recover_r};
      REG_RAMP:    cfg_prdata = {16'd0, ramp_r};
      default:     cfg_prdata = {20'd0, ccdet_r};
    endcase
  end

  // Control state.
  logic [2:0]  sq_r, sq_nxt;
  logic [1:0]  func_r;
  logic [SMP_BITS-1:0] smp_r [NUM_CH];
  logic [SMP_BITS-1:0] ring_r [NUM_CH][AVG_DEPTH];
  logic [SUM_BITS-1:0] sum_r [NUM_CH];
  logic [SLOT_BITS-1:0] slot_r;
  logic [2:0]  mode_r, mode_nxt;
  logic        en_r, en_nxt, ramping_r, ramping_nxt, chg_r, chg_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [11:0] rtarget_r, rtarget_nxt, vdac_r, vdac_nxt, idac_r, idac_nxt;
  logic        ring_we;
  logic        in_acc;
  logic        div_started_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  bss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Averages from the ring sums.
  logic [SMP_BITS-1:0] avg [NUM_CH];
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) avg[c] = sum_r[c][SUM_BITS-1:SLOT_BITS];
  end

  logic ntc_ok;
  assign ntc_ok = (avg[3] != '0) && (avg[3] != '1);

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (sq_r != SQ_IDLE);

  // Ring update on the cycle after acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= '0;
        for (int d = 0; d < AVG_DEPTH; d++) ring_r[c][d] <= '0;
      end
    end else if (ring_we) begin
      slot_r <= slot_r + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c]         <= sum_r[c] - SUM_BITS'(ring_r[c][slot_r]) + SUM_BITS'(smp_r[c]);
        ring_r[c][slot_r] <= smp_r[c];
      end
    end
  end

  assign ring_we = (sq_r == SQ_RING);

  // Sequencer.
  always_comb begin
    sq_nxt      = sq_r;
    mode_nxt    = mode_r;
    en_nxt      = en_r;
    ramping_nxt = ramping_r;
    chg_nxt     = chg_r;
    elapsed_nxt = elapsed_r;
    rtarget_nxt = rtarget_r;
    vdac_nxt    = vdac_r;
    idac_nxt    = idac_r;
    dreq.start    = 1'b0;
    dreq.dividend = 28'(rtarget_r) * 28'(elapsed_r);
    dreq.divisor  = ramp_r;
    unique case (sq_r)
      SQ_IDLE: begin
        if (in_acc) begin
          chg_nxt = 1'b0;
          sq_nxt  = (in_func == FUNC_TICK) ? SQ_RING : SQ_CMD;
        end
      end
      SQ_RING: begin
        sq_nxt = SQ_PROT;
        if (ramping_r) begin
          if (elapsed_r != 16'hFFFF) elapsed_nxt = elapsed_r + 1'b1;
          if (((elapsed_r != 16'hFFFF) ? elapsed_r + 1'b1 : elapsed_r) >= ramp_r) begin
            ramping_nxt = 1'b0;
            vdac_nxt    = vtarget_r;
            idac_nxt    = ilimit_r;
            if (mode_r != ST_RUN) chg_nxt = 1'b1;
            mode_nxt    = ST_RUN;
          end else begin
            sq_nxt = SQ_DIV;
          end
        end
      end
      SQ_DIV: begin
        // Start once with the updated count, then wait for the quotient.
        if (!drsp.done) begin
          dreq.start = !div_started_r;
        end
        if (drsp.done) begin
          vdac_nxt = (drsp.quotient > 28'd4095) ? 12'hFFF : drsp.quotient[11:0];
          sq_nxt   = SQ_PROT;
        end
      end
      SQ_PROT: begin
        sq_nxt = SQ_OUT;
        if (ntc_ok && avg[3] < ot_r) begin
          if (en_r) begin
            vdac_nxt = '0; idac_nxt = '0; en_nxt = 1'b0; ramping_nxt = 1'b0;
          end
          if (mode_r != ST_OTP) chg_nxt = 1'b1;
          mode_nxt = ST_OTP;
        end else if (en_r && avg[0] > ov_r) begin
          vdac_nxt = '0; idac_nxt = '0; en_nxt = 1'b0; ramping_nxt = 1'b0;
          if (mode_r != ST_OVP) chg_nxt = 1'b1;
          mode_nxt = ST_OVP;
        end else if (en_r && avg[1] > oc_r) begin
          vdac_nxt = '0; idac_nxt = '0; en_nxt = 1'b0; ramping_nxt = 1'b0;
          if (mode_r != ST_OCP) chg_nxt = 1'b1;
          mode_nxt = ST_OCP;
        end else if (en_r && (mode_r == ST_RUN || mode_r == ST_CV || mode_r == ST_CC)) begin
          mode_nxt = (avg[4] < ccdet_r) ? ST_CC : ST_CV;
          if (mode_nxt != mode_r) chg_nxt = 1'b1;
        end
      end
      SQ_CMD: begin
        sq_nxt = SQ_OUT;
        case (func_r)
          FUNC_ENABLE: begin
            if (!en_r && mode_r != ST_OTP && mode_r != ST_OVP && mode_r != ST_OCP) begin
              ramping_nxt = 1'b1;
              elapsed_nxt = '0;
              rtarget_nxt = vtarget_r;
              idac_nxt    = ilimit_r;
              en_nxt      = 1'b1;
              if (mode_r != ST_SOFT) chg_nxt = 1'b1;
              mode_nxt    = ST_SOFT;
            end
          end
          FUNC_DISABLE: begin
            if (en_r) begin
              vdac_nxt = '0; idac_nxt = '0; en_nxt = 1'b0; ramping_nxt = 1'b0;
              if (mode_r != ST_OFF) chg_nxt = 1'b1;
              mode_nxt = ST_OFF;
            end
          end
          default: begin
            if ((mode_r == ST_OTP || mode_r == ST_OVP || mode_r == ST_OCP) &&
                (!ntc_ok || avg[3] > recover_r)) begin
              chg_nxt  = 1'b1;
              mode_nxt = ST_OFF;
            end
          end
        endcase
      end
      SQ_OUT: sq_nxt = SQ_WAIT;
      SQ_WAIT: if (!out_stall) sq_nxt = SQ_IDLE;
      default: sq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r          <= SQ_IDLE;
      mode_r        <= ST_OFF;
      en_r          <= 1'b0;
      ramping_r     <= 1'b0;
      chg_r         <= 1'b0;
      elapsed_r     <= '0;
      rtarget_r     <= '0;
      vdac_r        <= '0;
      idac_r        <= '0;
      div_started_r <= 1'b0;
    end else begin
      sq_r          <= sq_nxt;
      mode_r        <= mode_nxt;
      en_r          <= en_nxt;
      ramping_r     <= ramping_nxt;
      chg_r         <= chg_nxt;
      elapsed_r     <= elapsed_nxt;
      rtarget_r     <= rtarget_nxt;
      vdac_r        <= vdac_nxt;
      idac_r        <= idac_nxt;
      div_started_r <= (sq_r == SQ_DIV) && !drsp.done;
    end
  end

  // Hold the command and samples of the accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_func;
      smp_r[0] <= in_vfb_sample;
      smp_r[1] <= in_ifb_sample;
      smp_r[2] <= in_vin_sample;
      smp_r[3] <= in_ntc_sample;
      smp_r[4] <= in_cc_sample;
    end
  end

  // Output registers, loaded once the result is final.
  logic [23:0] prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (sq_r == SQ_OUT) begin
      out_valid <= 1'b1;
    end else if (sq_r == SQ_WAIT && !out_stall) begin
      out_valid <= 1'b0;
    end
    prod_r <= 24'(avg[0]) * 24'(avg[1]);
    if (sq_r == SQ_OUT) begin
      out_voltage_dac   <= vdac_r;
      out_current_dac   <= idac_r;
      out_supply_state  <= mode_r;
      out_state_changed <= chg_r;
      out_output_on     <= en_r;
      out_vfb_average   <= avg[0];
      out_ifb_average   <= avg[1];
      out_vin_average   <= avg[2];
      out_ntc_average   <= avg[3];
      out_power_product <= prod_r;
    end
  end

endmodule : bench_supply_supervisor_top
`default_nettype wire
